// File: rtl/bvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg - shared types and constants of the battery voltage monitor
// Register map, configuration bundle, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package bvm_pkg;

	// port and datapath widths fixed by the field definitions
	localparam int ADC_W    = 12;
	localparam int MV_W     = 16;
	localparam int PCT_W    = 7;
	localparam int CNT_W    = 7;
	localparam int ALPHA_W  = 7;
	localparam int THR_W    = 10;
	localparam int FS_W     = 12;
	localparam int FALL_W   = 8;
	localparam int MUL_W    = 16;
	localparam int DIV_W    = 32;
	localparam int DEN_W    = 16;
	localparam int DCNT_W   = $clog2(DIV_W + 1);
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int RIDX_W   = 3;

	// register indexes (byte address = 4 * index)
	localparam logic [RIDX_W-1:0] REG_SAMPLES = 3'd0;
	localparam logic [RIDX_W-1:0] REG_VREF    = 3'd1;
	localparam logic [RIDX_W-1:0] REG_FSCALE  = 3'd2;
	localparam logic [RIDX_W-1:0] REG_ALPHA   = 3'd3;
	localparam logic [RIDX_W-1:0] REG_THRESH  = 3'd4;
	localparam logic [RIDX_W-1:0] REG_FULL    = 3'd5;
	localparam logic [RIDX_W-1:0] REG_EMPTY   = 3'd6;

	// register reset values
	localparam logic [CNT_W-1:0]   RST_SAMPLES = 7'd8;
	localparam logic [MV_W-1:0]    RST_VREF    = 16'd3300;
	localparam logic [FS_W-1:0]    RST_FSCALE  = 12'd4095;
	localparam logic [ALPHA_W-1:0] RST_ALPHA   = 7'd20;
	localparam logic [THR_W-1:0]   RST_THRESH  = 10'd5;
	localparam logic [MV_W-1:0]    RST_FULL    = 16'd2900;
	localparam logic [MV_W-1:0]    RST_EMPTY   = 16'd2000;

	// arithmetic constants
	localparam logic [ALPHA_W-1:0] PCT_FULL   = 7'd100;
	localparam logic [FALL_W-1:0]  FALL_MAX   = 8'hFF;
	localparam logic [FALL_W-1:0]  FALL_CLEAR = 8'd2;

	typedef struct packed {
		logic [CNT_W-1:0]   samples_per_reading;
		logic [MV_W-1:0]    vref_mv;
		logic [FS_W-1:0]    adc_full_scale;
		logic [ALPHA_W-1:0] ema_alpha_percent;
		logic [THR_W-1:0]   charge_threshold_mv;
		logic [MV_W-1:0]    full_mv;
		logic [MV_W-1:0]    empty_mv;
	} bvm_cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AVG_DIV,
		S_SCALE_MUL,
		S_SCALE_DIV,
		S_EMA_MUL1,
		S_EMA_MUL2,
		S_EMA_DIV,
		S_PCT_CHK,
		S_PCT_MUL,
		S_PCT_DIV,
		S_EMIT
	} bvm_state_t;

endpackage

// File: rtl/battery_voltage_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_monitor - smoothed battery voltage, level and charge state
// Averages ADC samples per reading, scales to mV, filters and judges charging.
// ----------------------------------------------------------------------------
// Each accepted adc word is added to the group sum. The word that closes a group
// starts a sequencer over one multiplier and one serial divider: average, scale
// to mV, EMA update and percent. The first reading only seeds the average and
// gives no result. The percent divide is skipped when the voltage sits at or
// beyond either end. adc_stall stays high for the whole sequence and while a
// finished result still waits for the previous one to be taken. Settings written
// mid-group apply to the current group. No clearing pass after reset.
// ----------------------------------------------------------------------------
module battery_voltage_monitor #(
	parameter int MAX_SAMPLES = 64,
	parameter int ADC_BITS    = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvm_pkg::ADDR_W-1:0]  paddr,
	input  logic [bvm_pkg::DATA_W-1:0]  pwdata,
	output logic [bvm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// sample channel
	input  logic                        adc_valid,
	output logic                        adc_stall,
	input  logic [bvm_pkg::ADC_W-1:0]   adc_sample,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [bvm_pkg::MV_W-1:0]    smooth_mv,
	output logic [bvm_pkg::PCT_W-1:0]   percent,
	output logic                        charging
);
	import bvm_pkg::*;

	localparam int USE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
	localparam int SUM_W = USE_W + CNT_W;

	bvm_cfg_t         cfg;
	bvm_state_t       state_q, state_d;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] idx_q;
	logic [MV_W-1:0]  ema_q;
	logic             primed_q;
	logic [FALL_W-1:0] fall_q;
	logic             flag_q;
	logic             issued_q;

	logic [MV_W-1:0]  reading_q;
	logic [DIV_W-1:0] acc_q;
	logic [PCT_W-1:0] pct_q;

	logic             res_valid_q;
	logic [MV_W-1:0]  res_mv_q;
	logic [PCT_W-1:0] res_pct_q;
	logic             res_chg_q;

	logic             accept;
	logic             grp_end;
	logic             out_free;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] idx_new;
	logic [CNT_W-1:0] grp_n;
	logic [FS_W-1:0]  fs;
	logic [ALPHA_W-1:0] alpha;
	logic [MV_W-1:0]  span;
	logic [MV_W-1:0]  mv_clamped;
	logic [MV_W-1:0]  ema_new;
	logic             rise;
	logic             fall;
	logic [FALL_W-1:0] fall_inc;

	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quot;
	logic [MUL_W-1:0] mul_a;
	logic [MUL_W-1:0] mul_b;
	logic [DIV_W-1:0] mul_p;

	bvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// clamp settings to their working ranges
	always_comb begin
		if (cfg.samples_per_reading == '0)
			grp_n = CNT_W'(1);
		else if (32'(cfg.samples_per_reading) > MAX_SAMPLES)
			grp_n = CNT_W'(MAX_SAMPLES);
		else
			grp_n = cfg.samples_per_reading;
		fs    = (cfg.adc_full_scale == '0) ? FS_W'(1) : cfg.adc_full_scale;
		alpha = (cfg.ema_alpha_percent > PCT_FULL) ? PCT_FULL : cfg.ema_alpha_percent;
		span  = cfg.full_mv - cfg.empty_mv;
	end

	// accumulate the incoming word
	assign adc_stall = (state_q != S_IDLE);
	assign accept    = adc_valid & ~adc_stall;
	assign sum_new   = sum_q + SUM_W'(adc_sample[USE_W-1:0]);
	assign idx_new   = idx_q + 1'b1;
	assign grp_end   = (idx_new >= grp_n);
	assign out_free  = ~res_valid_q | ~result_stall;

	// shared multiplier, registered into acc_q
	assign mul_p = mul_a * mul_b;

	// scaled reading saturates at full 16-bit range
	assign mv_clamped = (div_quot[DIV_W-1:MV_W] != '0) ? {MV_W{1'b1}} : div_quot[MV_W-1:0];

	// judge the EMA move against the threshold
	assign ema_new  = div_quot[MV_W-1:0];
	assign rise     = {1'b0, ema_new} > ({1'b0, ema_q} + (MV_W+1)'(cfg.charge_threshold_mv));
	assign fall     = ({1'b0, ema_new} + (MV_W+1)'(cfg.charge_threshold_mv)) < {1'b0, ema_q};
	assign fall_inc = (fall_q == FALL_MAX) ? fall_q : fall_q + 1'b1;

	// sequencer: next state and operand selection
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && grp_end)
					state_d = S_AVG_DIV;
			end
			S_AVG_DIV: begin
				div_start    = ~issued_q;
				div_dividend = DIV_W'(sum_q);
				div_divisor  = DEN_W'(grp_n);
				if (div_done)
					state_d = S_SCALE_MUL;
			end
			S_SCALE_MUL: begin
				mul_a   = reading_q;
				mul_b   = cfg.vref_mv;
				state_d = S_SCALE_DIV;
			end
			S_SCALE_DIV: begin
				div_start    = ~issued_q;
				div_dividend = acc_q;
				div_divisor  = DEN_W'(fs);
				if (div_done)
					state_d = primed_q ? S_EMA_MUL1 : S_IDLE;
			end
			S_EMA_MUL1: begin
				mul_a   = reading_q;
				mul_b   = MUL_W'(alpha);
				state_d = S_EMA_MUL2;
			end
			S_EMA_MUL2: begin
				mul_a   = ema_q;
				mul_b   = MUL_W'(PCT_FULL - alpha);
				state_d = S_EMA_DIV;
			end
			S_EMA_DIV: begin
				div_start    = ~issued_q;
				div_dividend = acc_q;
				div_divisor  = DEN_W'(PCT_FULL);
				if (div_done)
					state_d = S_PCT_CHK;
			end
			S_PCT_CHK: begin
				if (ema_q >= cfg.full_mv || ema_q <= cfg.empty_mv)
					state_d = S_EMIT;
				else
					state_d = S_PCT_MUL;
			end
			S_PCT_MUL: begin
				mul_a   = ema_q - cfg.empty_mv;
				mul_b   = MUL_W'(PCT_FULL);
				state_d = S_PCT_DIV;
			end
			S_PCT_DIV: begin
				div_start    = ~issued_q;
				div_dividend = acc_q;
				div_divisor  = span;
				if (div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			sum_q       <= '0;
			idx_q       <= '0;
			ema_q       <= '0;
			primed_q    <= 1'b0;
			fall_q      <= '0;
			flag_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// track the outstanding divide
			if (div_start)
				issued_q <= 1'b1;
			else if (div_done)
				issued_q <= 1'b0;

			// gather the group, restart it once averaged
			if (accept) begin
				sum_q <= sum_new;
				idx_q <= idx_new;
			end else if (state_q == S_AVG_DIV && div_done) begin
				sum_q <= '0;
				idx_q <= '0;
			end

			// seed the average on the first reading
			if (state_q == S_SCALE_DIV && div_done && !primed_q) begin
				ema_q    <= mv_clamped;
				primed_q <= 1'b1;
			end

			// update the average and the charge judgement
			if (state_q == S_EMA_DIV && div_done) begin
				ema_q <= ema_new;
				if (rise) begin
					flag_q <= 1'b1;
					fall_q <= '0;
				end else if (fall) begin
					fall_q <= fall_inc;
					if (fall_inc >= FALL_CLEAR)
						flag_q <= 1'b0;
				end else if (fall_q != '0) begin
					fall_q <= fall_q - 1'b1;
				end
			end

			// hold the result until taken
			if (state_q == S_EMIT && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_AVG_DIV: begin
				if (div_done)
					reading_q <= div_quot[MV_W-1:0];
			end
			S_SCALE_DIV: begin
				if (div_done)
					reading_q <= mv_clamped;
			end
			S_SCALE_MUL, S_EMA_MUL1, S_PCT_MUL: acc_q <= mul_p;
			S_EMA_MUL2: acc_q <= acc_q + mul_p;
			S_PCT_CHK: begin
				if (ema_q >= cfg.full_mv)
					pct_q <= PCT_FULL;
				else
					pct_q <= '0;
			end
			S_PCT_DIV: begin
				if (div_done)
					pct_q <= div_quot[PCT_W-1:0];
			end
			S_EMIT: begin
				if (out_free) begin
					res_mv_q  <= ema_q;
					res_pct_q <= pct_q;
					res_chg_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign smooth_mv    = res_mv_q;
	assign percent      = res_pct_q;
	assign charging     = res_chg_q;

endmodule

// File: rtl/bvm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_regs - configuration register file
// APB-style slave holding the seven settings; always ready, zero wait states.
// ----------------------------------------------------------------------------
module bvm_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bvm_pkg::ADDR_W-1:0] paddr,
	input  logic [bvm_pkg::DATA_W-1:0] pwdata,
	output logic [bvm_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output bvm_pkg::bvm_cfg_t          cfg
);
	import bvm_pkg::*;

	bvm_cfg_t          cfg_q;
	logic              wr_en;
	logic [RIDX_W-1:0] ridx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign ridx   = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// write a register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_reading <= RST_SAMPLES;
			cfg_q.vref_mv             <= RST_VREF;
			cfg_q.adc_full_scale      <= RST_FSCALE;
			cfg_q.ema_alpha_percent   <= RST_ALPHA;
			cfg_q.charge_threshold_mv <= RST_THRESH;
			cfg_q.full_mv             <= RST_FULL;
			cfg_q.empty_mv            <= RST_EMPTY;
		end else if (wr_en) begin
			case (ridx)
				REG_SAMPLES: cfg_q.samples_per_reading <= pwdata[CNT_W-1:0];
				REG_VREF:    cfg_q.vref_mv             <= pwdata[MV_W-1:0];
				REG_FSCALE:  cfg_q.adc_full_scale      <= pwdata[FS_W-1:0];
				REG_ALPHA:   cfg_q.ema_alpha_percent   <= pwdata[ALPHA_W-1:0];
				REG_THRESH:  cfg_q.charge_threshold_mv <= pwdata[THR_W-1:0];
				REG_FULL:    cfg_q.full_mv             <= pwdata[MV_W-1:0];
				REG_EMPTY:   cfg_q.empty_mv            <= pwdata[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		prdata = '0;
		case (ridx)
			REG_SAMPLES: prdata = DATA_W'(cfg_q.samples_per_reading);
			REG_VREF:    prdata = DATA_W'(cfg_q.vref_mv);
			REG_FSCALE:  prdata = DATA_W'(cfg_q.adc_full_scale);
			REG_ALPHA:   prdata = DATA_W'(cfg_q.ema_alpha_percent);
			REG_THRESH:  prdata = DATA_W'(cfg_q.charge_threshold_mv);
			REG_FULL:    prdata = DATA_W'(cfg_q.full_mv);
			REG_EMPTY:   prdata = DATA_W'(cfg_q.empty_mv);
			default:     prdata = '0;
		endcase
	end

endmodule

// File: rtl/bvm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_div - shared serial divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module bvm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bvm_pkg::DIV_W-1:0] dividend,
	input  logic [bvm_pkg::DEN_W-1:0] divisor,
	output logic                      done,
	output logic [bvm_pkg::DIV_W-1:0] quotient
);
	import bvm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    trial;
	logic              qbit;

	// trial subtract of the shifted partial remainder
	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign trial  = rem_sh - {1'b0, den_q};
	assign qbit   = ~trial[DEN_W];

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: bench/bvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_checker - scoreboard for the battery voltage monitor
// Follows register writes on the configuration port and every accepted ADC
// word, works out the gauge words the monitor owes, and compares each
// accepted result word field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module bvm_checker #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bvm_pkg::ADDR_W-1:0]  paddr,
	input  logic [bvm_pkg::DATA_W-1:0]  pwdata,
	input  logic                        adc_valid,
	input  logic                        adc_stall,
	input  logic [bvm_pkg::ADC_W-1:0]   adc_sample,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic [bvm_pkg::MV_W-1:0]    smooth_mv,
	input  logic [bvm_pkg::PCT_W-1:0]   percent,
	input  logic                        charging,
	output int                          errors,
	output int                          pending
);
	import bvm_pkg::*;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
		logic             chg;
	} gauge_t;

	gauge_t      gauge_q[$];
	bvm_cfg_t    cfg;
	int unsigned acc_sum;
	int unsigned acc_cnt;
	int unsigned ema;
	int unsigned falls;
	bit          seeded;
	bit          chg_flag;

	// samples per reading after the zero and upper limits are applied
	function automatic int unsigned group_len();
		int unsigned n;
		n = 32'(cfg.samples_per_reading);
		if (n == 0)
			n = 1;
		if (n > MAX_SAMPLES)
			n = MAX_SAMPLES;
		return n;
	endfunction

	// linear level between the empty and full voltages
	function automatic logic [PCT_W-1:0] level_of(input int unsigned mv);
		int unsigned full;
		int unsigned empty;
		full  = 32'(cfg.full_mv);
		empty = 32'(cfg.empty_mv);
		if (mv >= full)
			return PCT_FULL;
		if (mv <= empty)
			return '0;
		return PCT_W'(((mv - empty) * 100) / (full - empty));
	endfunction

	// accumulate one ADC word; close the group and queue the gauge word it owes
	task automatic take_word(input logic [ADC_W-1:0] word);
		int unsigned     n;
		int unsigned     fs;
		int unsigned     alpha;
		int unsigned     old;
		longint unsigned scaled;
		gauge_t          g;
		n = group_len();
		acc_sum += 32'(word);
		acc_cnt = (acc_cnt + 1) & 'h7F;
		if (acc_cnt < n)
			return;
		scaled = 64'(acc_sum / n);
		scaled = scaled * 64'(cfg.vref_mv);
		fs = (cfg.adc_full_scale == 0) ? 1 : 32'(cfg.adc_full_scale);
		scaled = scaled / 64'(fs);
		if (scaled > 'hFFFF)
			scaled = 'hFFFF;
		acc_sum = 0;
		acc_cnt = 0;
		// first reading only seeds the average
		if (!seeded) begin
			ema    = 32'(scaled);
			seeded = 1'b1;
			return;
		end
		alpha = 32'(cfg.ema_alpha_percent);
		if (alpha > 100)
			alpha = 100;
		old = ema;
		ema = 32'((64'(alpha) * scaled + 64'((100 - alpha) * old)) / 100);
		// judge rise, fall or flat against the threshold
		if (ema > old + 32'(cfg.charge_threshold_mv)) begin
			chg_flag = 1'b1;
			falls    = 0;
		end else if (ema + 32'(cfg.charge_threshold_mv) < old) begin
			if (falls < 32'(FALL_MAX))
				falls++;
			if (falls >= 32'(FALL_CLEAR))
				chg_flag = 1'b0;
		end else if (falls > 0) begin
			falls--;
		end
		g.mv  = ema[MV_W-1:0];
		g.pct = level_of(ema);
		g.chg = chg_flag;
		gauge_q.push_back(g);
	endtask

	function automatic void compare_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		gauge_t want;
		if (!arst_n) begin
			cfg.samples_per_reading = RST_SAMPLES;
			cfg.vref_mv             = RST_VREF;
			cfg.adc_full_scale      = RST_FSCALE;
			cfg.ema_alpha_percent   = RST_ALPHA;
			cfg.charge_threshold_mv = RST_THRESH;
			cfg.full_mv             = RST_FULL;
			cfg.empty_mv            = RST_EMPTY;
			acc_sum  = 0;
			acc_cnt  = 0;
			ema      = 0;
			falls    = 0;
			seeded   = 1'b0;
			chg_flag = 1'b0;
			gauge_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// check the result word against the oldest one owed
			if (result_valid && !result_stall) begin
				if (gauge_q.size() == 0) begin
					errors++;
					$display("%0t: result word with none owed: mv %0d, percent %0d, charging %0b",
						$time, smooth_mv, percent, charging);
				end else begin
					want = gauge_q.pop_front();
					compare_field("smooth_mv", 32'(want.mv), 32'(smooth_mv));
					compare_field("percent", 32'(want.pct), 32'(percent));
					compare_field("charging", 32'(want.chg), 32'(charging));
				end
			end
			// predict from the accepted ADC word
			if (adc_valid && !adc_stall)
				take_word(adc_sample);
			// mirror register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SAMPLES: cfg.samples_per_reading = pwdata[CNT_W-1:0];
					REG_VREF:    cfg.vref_mv             = pwdata[MV_W-1:0];
					REG_FSCALE:  cfg.adc_full_scale      = pwdata[FS_W-1:0];
					REG_ALPHA:   cfg.ema_alpha_percent   = pwdata[ALPHA_W-1:0];
					REG_THRESH:  cfg.charge_threshold_mv = pwdata[THR_W-1:0];
					REG_FULL:    cfg.full_mv             = pwdata[MV_W-1:0];
					REG_EMPTY:   cfg.empty_mv            = pwdata[MV_W-1:0];
					default: ;
				endcase
			end
			pending = gauge_q.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - top of the battery voltage monitor bench
// Programs the registers between phases, feeds ADC words with random gaps and
// stalls the result side at random; the checker beside the monitor predicts
// and compares. A short directed part covers the corner settings, then
// random phases drive battery-like trends, noise and extreme codes.
// ----------------------------------------------------------------------------
module tb;
	import bvm_pkg::*;

	localparam int MAX_SAMPLES = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 200;
	localparam int LONG_HOLD   = 400;
	localparam int RAND_ITEMS  = 1600;
	localparam logic [RIDX_W-1:0] REG_SPARE = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              adc_valid;
	logic              adc_stall;
	logic [ADC_W-1:0]  adc_sample;
	logic              result_valid;
	logic              result_stall;
	logic [MV_W-1:0]   smooth_mv;
	logic [PCT_W-1:0]  percent;
	logic              charging;

	int errors;
	int pending;
	int cycles = 0;
	bit adc_took = 1'b0;
	bit res_took = 1'b0;
	bit apb_took = 1'b0;
	bit hold_req;
	bit steady;

	battery_voltage_monitor #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.ADC_BITS    (ADC_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.adc_valid    (adc_valid),
		.adc_stall    (adc_stall),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.smooth_mv    (smooth_mv),
		.percent      (percent),
		.charging     (charging)
	);

	bvm_checker #(.MAX_SAMPLES(MAX_SAMPLES)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.adc_valid    (adc_valid),
		.adc_stall    (adc_stall),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.smooth_mv    (smooth_mv),
		.percent      (percent),
		.charging     (charging),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// latch the handshakes at the rising edge for the falling-edge drivers
	always @(posedge clk) begin
		adc_took <= adc_valid && !adc_stall;
		res_took <= result_valid && !result_stall;
		apb_took <= psel && penable && pwrite && pready;
	end

	// abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stall per word, one long hold-off on request
	initial begin : result_sink
		int w;
		result_stall <= 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				w = LONG_HOLD;
				hold_req = 1'b0;
			end else if (steady) begin
				w = 0;
			end else begin
				w = $urandom_range(0, 7);
			end
			if (w > 0) begin
				result_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(negedge clk); while (!res_took);
		end
	end

	function automatic logic [ADC_W-1:0] clamp_code(input int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return v[ADC_W-1:0];
	endfunction

	// two-phase register write; junk fills the bits above the register
	task automatic write_reg(input logic [RIDX_W-1:0] idx, input int unsigned val,
			input int width, input bit junk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= junk ? (($urandom << width) | val) : val;
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!apb_took);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// offer one ADC word after a random gap and hold it until taken
	task automatic send_word(input logic [ADC_W-1:0] word);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			adc_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		adc_valid  <= 1'b1;
		adc_sample <= word;
		do @(negedge clk); while (!adc_took);
	endtask

	// drop valid, wait for every owed word, then let a seeding pass finish
	task automatic settle();
		adc_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// random register set, extremes included
	task automatic pick_settings(input bit one_per_reading);
		int unsigned r;
		int unsigned spr;
		int unsigned vref;
		int unsigned fs;
		int unsigned alpha;
		int unsigned thr;
		int unsigned full;
		int unsigned empty;
		r = $urandom_range(0, 19);
		if (one_per_reading || r < 14)
			spr = one_per_reading ? 1 : $urandom_range(1, 4);
		else if (r < 16)
			spr = $urandom_range(5, 16);
		else if (r == 16)
			spr = 0;
		else if (r == 17)
			spr = 64;
		else if (r == 18)
			spr = $urandom_range(65, 127);
		else
			spr = $urandom_range(17, 63);
		case ($urandom_range(0, 3))
			0:       vref = 1;
			1:       vref = 65535;
			default: vref = $urandom_range(1000, 5000);
		endcase
		case ($urandom_range(0, 5))
			0:       fs = 0;
			1:       fs = 1;
			2, 3:    fs = 4095;
			default: fs = $urandom_range(1, 4095);
		endcase
		case ($urandom_range(0, 5))
			0:       alpha = 0;
			1:       alpha = 100;
			2:       alpha = $urandom_range(101, 127);
			default: alpha = $urandom_range(1, 99);
		endcase
		case ($urandom_range(0, 4))
			0:       thr = 0;
			1:       thr = 1023;
			2:       thr = 1000;
			default: thr = $urandom_range(0, 30);
		endcase
		case ($urandom_range(0, 4))
			0: begin
				full  = $urandom_range(0, 65535);
				empty = $urandom_range(0, 65535);
			end
			1: begin
				full  = 65535;
				empty = 0;
			end
			default: begin
				empty = $urandom_range(0, 3000);
				full  = empty + $urandom_range(1, 2000);
			end
		endcase
		write_reg(REG_SAMPLES, spr, CNT_W, 1'b1);
		write_reg(REG_VREF, vref, MV_W, 1'b1);
		write_reg(REG_FSCALE, fs, FS_W, 1'b1);
		write_reg(REG_ALPHA, alpha, ALPHA_W, 1'b1);
		write_reg(REG_THRESH, thr, THR_W, 1'b1);
		write_reg(REG_FULL, full, MV_W, 1'b1);
		write_reg(REG_EMPTY, empty, MV_W, 1'b1);
	endtask

	initial begin : stimulus
		int          level;
		int          slope;
		int          mode;
		int          k;
		int          phase;
		int unsigned count;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		adc_valid  = 1'b0;
		adc_sample = '0;
		hold_req   = 1'b0;
		steady     = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one word per reading: seed, two rises, two falls, two rises
		write_reg(REG_SAMPLES, 1, CNT_W, 1'b0);
		send_word(12'd0);
		send_word(12'd4095);
		send_word(12'd4095);
		send_word(12'd0);
		send_word(12'd0);
		send_word(12'd2048);
		send_word(12'd2048);
		settle();

		// zero group size, full weight, zero threshold, unmapped register
		write_reg(REG_SAMPLES, 0, CNT_W, 1'b0);
		write_reg(REG_ALPHA, 100, ALPHA_W, 1'b0);
		write_reg(REG_THRESH, 0, THR_W, 1'b0);
		write_reg(REG_SPARE, 'h5A5A, DATA_W, 1'b0);
		send_word(12'd4095);
		send_word(12'd0);
		send_word(12'd1);
		send_word(12'd1);
		settle();

		// millivolt clamp, zero full scale, weight above 100, full equal to empty
		write_reg(REG_VREF, 65535, MV_W, 1'b0);
		write_reg(REG_FSCALE, 0, FS_W, 1'b0);
		write_reg(REG_ALPHA, 127, ALPHA_W, 1'b0);
		write_reg(REG_THRESH, 1023, THR_W, 1'b0);
		write_reg(REG_FULL, 100, MV_W, 1'b0);
		write_reg(REG_EMPTY, 100, MV_W, 1'b0);
		send_word(12'd1);
		send_word(12'd4095);
		send_word(12'd0);
		settle();

		// group size lowered below the words already gathered
		write_reg(REG_VREF, 3300, MV_W, 1'b0);
		write_reg(REG_FSCALE, 4095, FS_W, 1'b0);
		write_reg(REG_ALPHA, 50, ALPHA_W, 1'b0);
		write_reg(REG_THRESH, 5, THR_W, 1'b0);
		write_reg(REG_FULL, 2900, MV_W, 1'b0);
		write_reg(REG_EMPTY, 2000, MV_W, 1'b0);
		write_reg(REG_SAMPLES, 4, CNT_W, 1'b0);
		repeat (3) send_word(12'd4000);
		settle();
		write_reg(REG_SAMPLES, 2, CNT_W, 1'b0);
		send_word(12'd4000);
		send_word(12'd1000);
		send_word(12'd1000);

		// random phases: mostly battery-like trends, some noise and extremes
		count = 0;
		phase = 0;
		while (count < RAND_ITEMS) begin
			settle();
			pick_settings(phase % 8 == 0);
			hold_req = (phase % 8 == 0);
			steady   = (phase % 5 == 3);
			mode  = $urandom_range(0, 9);
			level = $urandom_range(0, 4095);
			slope = 0;
			k     = $urandom_range(20, 80);
			repeat (k) begin
				if (mode < 7) begin
					if ($urandom_range(0, 15) == 0)
						slope = int'($urandom_range(0, 60)) - 30;
					level = clamp_code(level + slope);
					send_word(clamp_code(level + int'($urandom_range(0, 8)) - 4));
				end else if (mode < 9) begin
					send_word(ADC_W'($urandom_range(0, 4095)));
				end else begin
					send_word($urandom_range(0, 1) ? 12'd4095 : 12'd0);
				end
			end
			count += k;
			phase++;
		end
		steady = 1'b0;
		settle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: battery_voltage_monitor.f
rtl/bvm_pkg.sv
rtl/bvm_regs.sv
rtl/bvm_div.sv
rtl/battery_voltage_monitor.sv
bench/bvm_checker.sv
bench/tb.sv
